// ----- src/sst_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and keyword table for the source text tokenizer
package sst_pkg;

	localparam int POS_WIDTH_DEF   = 32;
	localparam int KEYWORD_MAX_DEF = 9;
	localparam int OUT_POS_W       = 32;
	localparam int QUEUE_DEPTH     = 8;
	localparam int SLOT_COUNT      = 4;
	localparam int MAX_PUSH        = 3;
	localparam int KW_COUNT        = 7;
	localparam int KW_LEN_MAX      = 9;

	typedef enum logic [4:0] {
		KIND_EOF        = 5'd0,
		KIND_UNKNOWN    = 5'd1,
		KIND_LPAREN     = 5'd2,
		KIND_RPAREN     = 5'd3,
		KIND_SEMI       = 5'd4,
		KIND_COLON      = 5'd5,
		KIND_LBRACE     = 5'd6,
		KIND_COMMA      = 5'd7,
		KIND_EQUALS     = 5'd8,
		KIND_RBRACE     = 5'd9,
		KIND_DOT        = 5'd10,
		KIND_UNDERSCORE = 5'd11,
		KIND_ARROW      = 5'd12,
		KIND_NUMBER     = 5'd13,
		KIND_IDENT      = 5'd14,
		KIND_PROC       = 5'd15,
		KIND_FN         = 5'd16,
		KIND_RET        = 5'd17,
		KIND_DATA       = 5'd18,
		KIND_MATCH      = 5'd19,
		KIND_UNION      = 5'd20,
		KIND_OTHERWISE  = 5'd21
	} token_kind_t;

	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_NUMBER,
		MODE_IDENT,
		MODE_DASH,
		MODE_SLASH,
		MODE_EOLHALF,
		MODE_COMMENT,
		MODE_COMMENT_EOL
	} scan_mode_t;

	typedef enum logic [1:0] {
		EOL_LF   = 2'd0,
		EOL_CRLF = 2'd1,
		EOL_CR   = 2'd2,
		EOL_LFCR = 2'd3
	} eol_mode_t;

	typedef struct packed {
		token_kind_t       kind;
		logic [OUT_POS_W-1:0] first_pos;
		logic [OUT_POS_W-1:0] last_pos;
		logic              is_final;
	} token_t;

	typedef struct packed {
		logic [SLOT_COUNT-1:0]   valid;
		token_t [SLOT_COUNT-1:0] slot;
	} push_t;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_LEN_MAX] = '{
		'{"p", "r", "o", "c", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"d", "a", "t", "a", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"m", "a", "t", "c", "h", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"u", "n", "i", "o", "n", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"o", "t", "h", "e", "r", "w", "i", "s", "e"}
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd4, 4'd2, 4'd3, 4'd4, 4'd5, 4'd5, 4'd9
	};

	localparam token_kind_t KW_KIND [KW_COUNT] = '{
		KIND_PROC, KIND_FN, KIND_RET, KIND_DATA, KIND_MATCH, KIND_UNION, KIND_OTHERWISE
	};

	// single-byte punctuation, KIND_EOF when the byte is none of them
	function automatic token_kind_t punct_kind(input logic [7:0] b);
		token_kind_t k;
		case (b)
			"(":      k = KIND_LPAREN;
			")":      k = KIND_RPAREN;
			";":      k = KIND_SEMI;
			":":      k = KIND_COLON;
			"{":      k = KIND_LBRACE;
			",":      k = KIND_COMMA;
			"=":      k = KIND_EQUALS;
			"}":      k = KIND_RBRACE;
			".":      k = KIND_DOT;
			CH_UNDER: k = KIND_UNDERSCORE;
			default:  k = KIND_EOF;
		endcase
		return k;
	endfunction

endpackage

// ----- src/sst_scan.sv -----
`timescale 1ns / 1ps
// scanner state and the combinational scan step for one text byte
module sst_scan #(
	parameter int POS_WIDTH   = sst_pkg::POS_WIDTH_DEF,
	parameter int KEYWORD_MAX = sst_pkg::KEYWORD_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               char_valid,
	input  logic [7:0]         symbol,
	input  logic               end_of_text,
	input  sst_pkg::eol_mode_t eol_mode,
	output sst_pkg::push_t     push
);
	import sst_pkg::*;

	localparam int WL_W = $clog2(KEYWORD_MAX + 2);

	logic [POS_WIDTH-1:0] position_q, token_start_q, last_pos_q;
	scan_mode_t           mode_q;
	logic [WL_W-1:0]      word_len_q;
	logic                 finished_q;
	logic [7:0]           word_q [KEYWORD_MAX];

	// decode
	logic        cv, eot, cont, rescan, flush_byte;
	logic [7:0]  eol1, eol2;
	logic        eol_single, is_digit, is_alpha, is_blank;
	token_kind_t pk;
	logic        idle_emit;
	token_kind_t idle_kind;

	// state after the byte, before end of text
	scan_mode_t           mode_b, mode_d;
	logic [POS_WIDTH-1:0] tok_b, pos_b, last_b, pos_inc;
	logic [7:0]           word_b [KEYWORD_MAX];
	logic [WL_W-1:0]      len_b;
	logic                 finished_d;

	function automatic token_kind_t word_kind(input logic [7:0] w [KEYWORD_MAX],
		input logic [WL_W-1:0] len);
		token_kind_t k;
		logic        hit;
		k = KIND_IDENT;
		if (len <= WL_W'(KEYWORD_MAX)) begin
			for (int kk = 0; kk < KW_COUNT; kk++) begin
				hit = (WL_W'(KW_LEN[kk]) == len);
				for (int i = 0; i < KW_LEN_MAX; i++) begin
					if (WL_W'(i) < len && w[i] != KW_TEXT[kk][i])
						hit = 1'b0;
				end
				if (hit)
					k = KW_KIND[kk];
			end
		end
		return k;
	endfunction

	function automatic logic [OUT_POS_W-1:0] out_pos(input logic [POS_WIDTH-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[OUT_POS_W-1:0];
	endfunction

	always_comb begin
		cv  = char_valid && !finished_q;
		eot = end_of_text && !finished_q;
		eol1 = (eol_mode == EOL_CRLF || eol_mode == EOL_CR) ? CH_CR : CH_LF;
		eol2 = (eol_mode == EOL_CRLF) ? CH_LF : CH_CR;
		eol_single = (eol_mode == EOL_LF || eol_mode == EOL_CR);
		is_digit = symbol inside {["0":"9"]};
		is_alpha = symbol inside {["a":"z"], ["A":"Z"]};
		is_blank = symbol inside {CH_SPACE, CH_TAB, CH_VT};
		pk = punct_kind(symbol);
		case (mode_q)
			MODE_NUMBER:      cont = is_digit || symbol == CH_UNDER;
			MODE_IDENT:       cont = is_digit || is_alpha;
			MODE_DASH:        cont = (symbol == CH_GT);
			MODE_SLASH:       cont = (symbol == CH_SLASH);
			MODE_EOLHALF:     cont = (symbol == eol2);
			MODE_COMMENT:     cont = 1'b1;
			MODE_COMMENT_EOL: cont = 1'b1;
			default:          cont = 1'b0;
		endcase
		rescan     = cv && !cont;
		flush_byte = rescan && mode_q != MODE_IDLE;
		// a byte scanned from idle that yields a one-character token at once
		idle_emit = 1'b0;
		idle_kind = KIND_UNKNOWN;
		if (symbol != eol1 && !is_blank) begin
			if (pk != KIND_EOF) begin
				idle_emit = 1'b1;
				idle_kind = pk;
			end else if (symbol != CH_DASH && symbol != CH_SLASH && !is_digit && !is_alpha)
				idle_emit = 1'b1;
		end
	end

	// next state
	always_comb begin
		mode_b = mode_q;
		tok_b  = token_start_q;
		word_b = word_q;
		len_b  = word_len_q;
		pos_inc = (position_q == {POS_WIDTH{1'b1}}) ? position_q
			: position_q + POS_WIDTH'(1);
		if (cv) begin
			case (mode_q)
				MODE_IDENT: begin
					if (cont) begin
						for (int i = 0; i < KEYWORD_MAX; i++) begin
							if (word_len_q == WL_W'(i))
								word_b[i] = symbol;
						end
						if (word_len_q <= WL_W'(KEYWORD_MAX))
							len_b = word_len_q + WL_W'(1);
					end
				end
				MODE_DASH: begin
					if (cont)
						mode_b = MODE_IDLE;
				end
				MODE_SLASH: begin
					if (cont)
						mode_b = MODE_COMMENT;
				end
				MODE_EOLHALF: begin
					if (cont)
						mode_b = MODE_IDLE;
				end
				MODE_COMMENT: begin
					if (symbol == eol1)
						mode_b = eol_single ? MODE_IDLE : MODE_COMMENT_EOL;
				end
				MODE_COMMENT_EOL: begin
					if (symbol == eol2)
						mode_b = MODE_IDLE;
					else if (symbol != eol1)
						mode_b = MODE_COMMENT;
				end
				default: ;
			endcase
			if (rescan) begin
				mode_b = MODE_IDLE;
				if (symbol == eol1) begin
					if (!eol_single) begin
						mode_b = MODE_EOLHALF;
						tok_b  = position_q;
					end
				end else if (!is_blank && pk == KIND_EOF) begin
					tok_b = position_q;
					if (symbol == CH_DASH)
						mode_b = MODE_DASH;
					else if (symbol == CH_SLASH)
						mode_b = MODE_SLASH;
					else if (is_digit)
						mode_b = MODE_NUMBER;
					else if (is_alpha) begin
						mode_b    = MODE_IDENT;
						word_b[0] = symbol;
						len_b     = WL_W'(1);
					end
				end
			end
		end
		pos_b  = cv ? pos_inc : position_q;
		last_b = cv ? position_q : last_pos_q;
		mode_d     = eot ? MODE_IDLE : mode_b;
		finished_d = finished_q || eot;
	end

	// results of this step, in emission order
	always_comb begin
		push = '0;

		push.valid[0] = flush_byte;
		push.slot[0].first_pos = out_pos(token_start_q);
		case (mode_q)
			MODE_NUMBER: begin
				push.slot[0].kind     = KIND_NUMBER;
				push.slot[0].last_pos = out_pos(last_pos_q);
			end
			MODE_IDENT: begin
				push.slot[0].kind     = word_kind(word_q, word_len_q);
				push.slot[0].last_pos = out_pos(last_pos_q);
			end
			default: begin
				push.slot[0].kind     = KIND_UNKNOWN;
				push.slot[0].last_pos = out_pos(token_start_q);
			end
		endcase

		if (cv && mode_q == MODE_DASH && cont) begin
			push.valid[1]          = 1'b1;
			push.slot[1].kind      = KIND_ARROW;
			push.slot[1].first_pos = out_pos(token_start_q);
			push.slot[1].last_pos  = out_pos(position_q);
		end else begin
			push.valid[1]          = rescan && idle_emit;
			push.slot[1].kind      = idle_kind;
			push.slot[1].first_pos = out_pos(position_q);
			push.slot[1].last_pos  = out_pos(position_q);
		end

		// end of text flushes whatever is pending after the byte
		push.slot[2].first_pos = out_pos(tok_b);
		case (mode_b)
			MODE_NUMBER: begin
				push.valid[2]         = eot;
				push.slot[2].kind     = KIND_NUMBER;
				push.slot[2].last_pos = out_pos(last_b);
			end
			MODE_IDENT: begin
				push.valid[2]         = eot;
				push.slot[2].kind     = word_kind(word_b, len_b);
				push.slot[2].last_pos = out_pos(last_b);
			end
			MODE_DASH, MODE_SLASH, MODE_EOLHALF: begin
				push.valid[2]         = eot;
				push.slot[2].kind     = KIND_UNKNOWN;
				push.slot[2].last_pos = out_pos(tok_b);
			end
			default: begin
				push.valid[2]         = 1'b0;
				push.slot[2].kind     = KIND_UNKNOWN;
				push.slot[2].last_pos = out_pos(tok_b);
			end
		endcase

		push.valid[3]          = eot;
		push.slot[3].kind      = KIND_EOF;
		push.slot[3].first_pos = out_pos(pos_b);
		push.slot[3].last_pos  = out_pos(pos_b);
		push.slot[3].is_final  = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q    <= POS_WIDTH'(1);
			mode_q        <= MODE_IDLE;
			token_start_q <= '0;
			last_pos_q    <= '0;
			word_len_q    <= '0;
			finished_q    <= 1'b0;
		end else if (accept) begin
			position_q    <= pos_b;
			mode_q        <= mode_d;
			token_start_q <= tok_b;
			last_pos_q    <= last_b;
			word_len_q    <= len_b;
			finished_q    <= finished_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			word_q <= word_b;
	end

endmodule

// ----- src/sst_fifo.sv -----
`timescale 1ns / 1ps
// token queue: takes up to three tokens a cycle, hands out one a cycle while the head is not stalled
module sst_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  sst_pkg::push_t  push,
	output sst_pkg::token_t head,
	output logic            head_valid,
	input  logic            head_stall,
	output logic            full
);
	import sst_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	token_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q, npush;
	logic [PTR_W-1:0] addr [SLOT_COUNT];
	logic             pop;

	// pack the valid slots into consecutive entries
	always_comb begin
		npush = '0;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			addr[s] = wr_q + npush[PTR_W-1:0];
			if (push.valid[s])
				npush = npush + CNT_W'(1);
		end
	end

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_q];
	assign pop        = head_valid && !head_stall;
	assign full       = (count_q > CNT_W'(QUEUE_DEPTH - MAX_PUSH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + npush[PTR_W-1:0];
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + npush - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < SLOT_COUNT; s++) begin
			if (push.valid[s])
				mem_q[addr[s]] <= push.slot[s];
		end
	end

endmodule

// ----- src/source_text_tokenizer.sv -----
`timescale 1ns / 1ps
// Streaming tokenizer for source text: one byte in, tokens out.
//
// Input channel (in_valid / in_stall): each transfer carries char_valid,
// symbol and end_of_text. One byte can be taken every cycle while in_stall is
// low; the byte is scanned in the cycle it is taken, and the tokens it
// completes (up to three) are written to an eight-entry token queue at that edge.
// Output channel (out_valid / out_stall): one token per transfer, the
// earliest first; a queued token shows once the tokens ahead of it have gone.
// The queue drains one token per cycle while out_stall is low; in_stall
// rises while fewer than three entries are free, so a burst of short
// tokens slows the input to the output rate.
// Configuration (cfg_valid / cfg_ready / cfg_data): sets the line end
// sequence; ready is always high. Write it only while the block is idle.
// Reset clears the scanner (position back to 1), empties the queue and
// selects LF line ends. After an end_of_text transfer the EOF token is
// queued and later bytes are taken and ignored until the next reset.
// A stalled output holds its token; bytes keep flowing until in_stall rises.
module source_text_tokenizer #(
	parameter int POS_WIDTH   = sst_pkg::POS_WIDTH_DEF,
	parameter int KEYWORD_MAX = sst_pkg::KEYWORD_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        char_valid,
	input  logic [7:0]  symbol,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  token_kind,
	output logic [31:0] start_pos,
	output logic [31:0] end_pos,
	output logic        is_final,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);
	import sst_pkg::*;

	eol_mode_t eol_mode_q;
	logic      accept;
	logic      queue_full;
	push_t     scan_push, queue_push;
	token_t    head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			eol_mode_q <= EOL_LF;
		else if (cfg_valid && cfg_ready)
			eol_mode_q <= eol_mode_t'(cfg_data);
	end

	assign in_stall = queue_full;
	assign accept   = in_valid && !in_stall;

	sst_scan #(
		.POS_WIDTH  (POS_WIDTH),
		.KEYWORD_MAX(KEYWORD_MAX)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_valid (char_valid),
		.symbol     (symbol),
		.end_of_text(end_of_text),
		.eol_mode   (eol_mode_q),
		.push       (scan_push)
	);

	// only a transfer writes the queue
	always_comb begin
		queue_push       = scan_push;
		queue_push.valid = scan_push.valid & {SLOT_COUNT{accept}};
	end

	sst_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (queue_push),
		.head      (head),
		.head_valid(out_valid),
		.head_stall(out_stall),
		.full      (queue_full)
	);

	assign token_kind = head.kind;
	assign start_pos  = head.first_pos;
	assign end_pos    = head.last_pos;
	assign is_final   = head.is_final;

	a_stall_needs_tokens: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty token queue");

	a_push_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(queue_push.valid) <= MAX_PUSH)
		else $error("more than three tokens from one byte");

	a_final_is_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_final) |-> (token_kind == KIND_EOF))
		else $error("final flag on a token that is not EOF");

	a_eof_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && token_kind == KIND_EOF) |-> is_final)
		else $error("EOF token without final flag");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// testbench for source_text_tokenizer: byte stream stimulus, token predictor and scoreboard
module tb;
	import sst_pkg::*;

	localparam int          CYCLE_LIMIT = 300000;
	localparam int          KW_LIMIT    = 9;
	localparam logic [7:0]  LF_BYTE     = 8'h0A;
	localparam logic [7:0]  CR_BYTE     = 8'h0D;
	localparam logic [7:0]  TAB_BYTE    = 8'h09;
	localparam logic [7:0]  VT_BYTE     = 8'h0B;

	// predicts the token stream and checks what comes out
	class token_scoreboard;
		eol_mode_t  line_end;
		scan_mode_t mode;
		bit [31:0]  next_pos;
		bit [31:0]  prev_pos;
		bit [31:0]  tok_start;
		bit [71:0]  word_bits;
		bit [3:0]   word_len;
		bit         done;
		token_t     expected[$];
		int         errors;

		function new();
			line_end  = EOL_LF;
			mode      = MODE_IDLE;
			next_pos  = 1;
			prev_pos  = 0;
			tok_start = 0;
			word_bits = '0;
			word_len  = 0;
			done      = 1'b0;
			errors    = 0;
		endfunction

		function void set_line_end(eol_mode_t m);
			line_end = m;
		endfunction

		function int outstanding();
			return expected.size();
		endfunction

		function void push_token(token_kind_t k, bit [31:0] s, bit [31:0] e,
			bit fin = 1'b0);
			token_t t;
			t.kind      = k;
			t.first_pos = s;
			t.last_pos  = e;
			t.is_final  = fin;
			expected.push_back(t);
		endfunction

		function bit [7:0] eol_head();
			return (line_end == EOL_CRLF || line_end == EOL_CR) ? CR_BYTE : LF_BYTE;
		endfunction

		function bit [7:0] eol_tail();
			return (line_end == EOL_CRLF) ? LF_BYTE : CR_BYTE;
		endfunction

		function bit eol_one();
			return line_end == EOL_LF || line_end == EOL_CR;
		endfunction

		function bit is_digit(bit [7:0] b);
			return b >= "0" && b <= "9";
		endfunction

		function bit is_letter(bit [7:0] b);
			return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
		endfunction

		function token_kind_t punct_of(bit [7:0] b);
			case (b)
				"(": return KIND_LPAREN;
				")": return KIND_RPAREN;
				";": return KIND_SEMI;
				":": return KIND_COLON;
				"{": return KIND_LBRACE;
				",": return KIND_COMMA;
				"=": return KIND_EQUALS;
				"}": return KIND_RBRACE;
				".": return KIND_DOT;
				"_": return KIND_UNDERSCORE;
				default: return KIND_EOF;
			endcase
		endfunction

		// only words of up to nine bytes can be keywords
		function token_kind_t word_kind();
			if (word_len > KW_LIMIT)
				return KIND_IDENT;
			case (word_bits)
				"proc":      return KIND_PROC;
				"fn":        return KIND_FN;
				"ret":       return KIND_RET;
				"data":      return KIND_DATA;
				"match":     return KIND_MATCH;
				"union":     return KIND_UNION;
				"otherwise": return KIND_OTHERWISE;
				default:     return KIND_IDENT;
			endcase
		endfunction

		function void close_token();
			case (mode)
				MODE_NUMBER: push_token(KIND_NUMBER, tok_start, prev_pos);
				MODE_IDENT: push_token(word_kind(), tok_start, prev_pos);
				MODE_DASH, MODE_SLASH, MODE_EOLHALF: push_token(KIND_UNKNOWN, tok_start, tok_start);
				default: ;
			endcase
			mode = MODE_IDLE;
		endfunction

		function void open_token(bit [7:0] b, bit [31:0] p);
			token_kind_t k;
			mode = MODE_IDLE;
			if (b == eol_head()) begin
				if (!eol_one()) begin
					mode      = MODE_EOLHALF;
					tok_start = p;
				end
				return;
			end
			if (b == " " || b == TAB_BYTE || b == VT_BYTE)
				return;
			k = punct_of(b);
			if (k != KIND_EOF) begin
				push_token(k, p, p);
				return;
			end
			tok_start = p;
			if (b == "-")
				mode = MODE_DASH;
			else if (b == "/")
				mode = MODE_SLASH;
			else if (is_digit(b))
				mode = MODE_NUMBER;
			else if (is_letter(b)) begin
				mode      = MODE_IDENT;
				word_bits = 72'(b);
				word_len  = 1;
			end else
				push_token(KIND_UNKNOWN, p, p);
		endfunction

		function void note_item(bit cv, bit [7:0] b, bit eot);
			bit [31:0] p;
			if (done)
				return;
			if (cv) begin
				p = next_pos;
				case (mode)
					MODE_NUMBER: begin
						if (!(is_digit(b) || b == "_")) begin
							close_token();
							open_token(b, p);
						end
					end
					MODE_IDENT: begin
						if (is_letter(b) || is_digit(b)) begin
							if (word_len < KW_LIMIT)
								word_bits = {word_bits[63:0], b};
							if (word_len <= KW_LIMIT)
								word_len++;
						end else begin
							close_token();
							open_token(b, p);
						end
					end
					MODE_DASH: begin
						if (b == ">") begin
							push_token(KIND_ARROW, tok_start, p);
							mode = MODE_IDLE;
						end else begin
							close_token();
							open_token(b, p);
						end
					end
					MODE_SLASH: begin
						if (b == "/")
							mode = MODE_COMMENT;
						else begin
							close_token();
							open_token(b, p);
						end
					end
					MODE_EOLHALF: begin
						if (b == eol_tail())
							mode = MODE_IDLE;
						else begin
							close_token();
							open_token(b, p);
						end
					end
					MODE_COMMENT: begin
						if (b == eol_head()) begin
							if (eol_one())
								mode = MODE_IDLE;
							else
								mode = MODE_COMMENT_EOL;
						end
					end
					MODE_COMMENT_EOL: begin
						if (b == eol_tail())
							mode = MODE_IDLE;
						else if (b != eol_head())
							mode = MODE_COMMENT;
					end
					default: open_token(b, p);
				endcase
				prev_pos = p;
				next_pos = (p == 32'hFFFF_FFFF) ? p : p + 32'd1;
			end
			if (eot) begin
				close_token();
				push_token(KIND_EOF, next_pos, next_pos, 1'b1);
				done = 1'b1;
			end
		endfunction

		function void check_token(logic [4:0] kind, logic [31:0] s, logic [31:0] e,
			logic fin);
			token_t t;
			if (expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected token kind %0d start %0d end %0d final %0d",
					$time, kind, s, e, fin);
				return;
			end
			t = expected.pop_front();
			if (kind !== t.kind || s !== t.first_pos || e !== t.last_pos
				|| fin !== t.is_final) begin
				errors++;
				$display({"%0t: token mismatch: expected kind %0d start %0d end %0d final %0d,",
					" actual kind %0d start %0d end %0d final %0d"},
					$time, t.kind, t.first_pos, t.last_pos, t.is_final, kind, s, e, fin);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        char_valid;
	logic [7:0]  symbol;
	logic        end_of_text;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  token_kind;
	logic [31:0] start_pos;
	logic [31:0] end_pos;
	logic        is_final;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_data;

	token_scoreboard sb;
	int          send_idle;
	int          recv_idle;
	int          items_sent;
	int          cycle_count = 0;
	eol_mode_t   cur_eol;
	string       keywords[7] = '{"proc", "fn", "ret", "data", "match", "union", "otherwise"};
	string       puncts = "(){};:,=._";

	source_text_tokenizer DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_valid  (char_valid),
		.symbol      (symbol),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.start_pos   (start_pos),
		.end_pos     (end_pos),
		.is_final    (is_final),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_item(char_valid, symbol, end_of_text);
			if (out_valid && !out_stall)
				sb.check_token(token_kind, start_pos, end_pos, is_final);
		end
	end

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < recv_idle);

	task automatic send_item(input bit cv, input bit [7:0] b, input bit eot);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		char_valid  <= cv;
		symbol      <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (cv)
			items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(1'b1, s[i], 1'b0);
	endtask

	function automatic string eol_text(eol_mode_t m);
		case (m)
			EOL_CRLF: return "\r\n";
			EOL_CR:   return "\r";
			EOL_LFCR: return "\n\r";
			default:  return "\n";
		endcase
	endfunction

	function automatic bit [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return 8'h61 + 8'($urandom_range(0, 25));
		return 8'h41 + 8'($urandom_range(0, 25));
	endfunction

	function automatic bit [7:0] rand_alnum();
		if ($urandom_range(0, 3) == 0)
			return 8'h30 + 8'($urandom_range(0, 9));
		return rand_letter();
	endfunction

	task automatic send_blank();
		case ($urandom_range(0, 2))
			0: send_item(1'b1, " ", 1'b0);
			1: send_item(1'b1, TAB_BYTE, 1'b0);
			default: send_item(1'b1, VT_BYTE, 1'b0);
		endcase
	endtask

	// mostly well-formed tokens, with stray line end bytes and noise mixed in
	task automatic random_phrase();
		int n;
		case ($urandom_range(0, 15))
			0, 1, 2: begin
				send_text(keywords[$urandom_range(0, 6)]);
				if ($urandom_range(0, 3) != 0)
					send_blank();
			end
			3: begin
				n = $urandom_range(1, 13);
				send_item(1'b1, rand_letter(), 1'b0);
				repeat (n - 1)
					send_item(1'b1, rand_alnum(), 1'b0);
			end
			4: begin
				send_item(1'b1, 8'h30 + 8'($urandom_range(0, 9)), 1'b0);
				repeat ($urandom_range(0, 5))
					send_item(1'b1, ($urandom_range(0, 3) == 0) ? 8'h5F
						: 8'h30 + 8'($urandom_range(0, 9)), 1'b0);
			end
			5, 6: send_item(1'b1, puncts[$urandom_range(0, 9)], 1'b0);
			7: send_text("->");
			8: send_blank();
			9: send_text(eol_text(cur_eol));
			10: begin
				send_text("//");
				repeat ($urandom_range(0, 6))
					send_item(1'b1, 8'($urandom_range(32, 126)), 1'b0);
				send_text(eol_text(cur_eol));
			end
			11: send_item(1'b1, $urandom_range(0, 1) ? "-" : "/", 1'b0);
			12: send_item(1'b1, $urandom_range(0, 1) ? CR_BYTE : LF_BYTE, 1'b0);
			13: send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0);
			14: send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
			default: begin
				// comment holding stray and partial line end bytes
				send_text("//");
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 2))
						0: send_item(1'b1, CR_BYTE, 1'b0);
						1: send_item(1'b1, LF_BYTE, 1'b0);
						default: send_item(1'b1, 8'($urandom_range(32, 126)), 1'b0);
					endcase
				end
				send_text(eol_text(cur_eol));
			end
		endcase
	endtask

	// line end is only changed once every token has drained
	task automatic write_line_end(input eol_mode_t m);
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_line_end(m);
		cur_eol = m;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		eol_mode_t seg_modes[6] = '{EOL_LFCR, EOL_CR, EOL_LF, EOL_CRLF, EOL_LFCR, EOL_CR};
		int target;
		sb          = new();
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		char_valid  = 1'b0;
		symbol      = 8'h00;
		end_of_text = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = EOL_LF;
		send_idle   = 36;
		recv_idle   = 55;
		items_sent  = 0;
		cur_eol     = EOL_LF;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// all punctuation, number with underscore, lone dash and slash, foreign CR
		send_text("(){};:,=._->");
		send_item(1'b0, 8'hA5, 1'b0);
		send_text("7_ -a/b\r\n");
		send_item(1'b1, 8'h00, 1'b0);
		send_item(1'b1, 8'hFF, 1'b0);
		send_item(1'b1, " ", 1'b0);

		// two byte line end: broken halves, foreign LF, comment with repeated CR
		write_line_end(EOL_CRLF);
		send_text("\r\n\rx\n//c\r\r\n ");

		for (int seg = 0; seg < 6; seg++) begin
			if (seg == 2) begin
				send_idle = 55;
				recv_idle = 36;
			end else if (seg == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_line_end(seg_modes[seg]);
			target = items_sent + 55;
			while (items_sent < target)
				random_phrase();
		end

		// only one end of text per run, so the ending flavor is picked at random
		send_text({eol_text(cur_eol), " "});
		case ($urandom_range(0, 3))
			0: begin
				send_text("//ab");
				send_item(1'b1, "c", 1'b1);
			end
			1: begin
				send_text("word");
				send_item(1'b0, 8'h00, 1'b1);
			end
			2: begin
				send_text("12");
				send_item(1'b1, "-", 1'b1);
			end
			default: begin
				send_text("data");
				send_item(1'b1, "/", 1'b1);
			end
		endcase
		// transfers after the end are swallowed
		repeat (4)
			send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
		@(negedge clk);
		in_valid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
